// ===== hdl/bba_pkg.sv =====
package bba_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int POOL_UNITS = 1 << TREE_LEVELS;
  localparam int NODE_COUNT = (1 << (TREE_LEVELS + 1)) - 1;
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int LVL_W = $clog2(TREE_LEVELS + 1);
  localparam int LEFT_W = TREE_LEVELS;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADBLOCK = 2'd2;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_TAKEN = 2'd1;
  localparam logic [1:0] MARK_SPLIT = 2'd2;
  localparam logic [1:0] MARK_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [10:0] request_units;
    logic [9:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_offset;
    logic [10:0] block_units;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START,
    S_A_RD, S_A_CHK, S_A_C1, S_A_C2, S_A_ADV,
    S_F_RD, S_F_CHK,
    S_Q_RD, S_Q_CHK,
    S_R_RD, S_R_CHK, S_U_RD, S_U_CHK,
    S_DONE
  } state_t;

  typedef enum logic {RD_NODE, RD_SIB} rsel_t;
  typedef enum logic [2:0] {WS_NODE, WS_CHILD_L, WS_CHILD_R, WS_PARENT, WS_CLEAR} wsel_t;
  typedef enum logic [2:0] {MV_HOLD, MV_LEFT, MV_RIGHT, MV_NEXT, MV_UP} move_t;
  typedef enum logic [2:0] {RS_NONE, RS_GRANT, RS_FOUND, RS_FAIL_NS, RS_FAIL_BAD} res_t;

  typedef struct packed {
    logic clr;
    logic load;
    rsel_t rsel;
    logic we;
    wsel_t wsel;
    logic [1:0] wmark;
    move_t move;
    res_t res;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic too_large;
    logic off_bad;
    logic [1:0] mark;
    logic at_target;
    logic leaf;
    logic n_root;
    logic n_odd;
    logic go_left;
    logic off_eq_left;
    logic clr_last;
  } sts_t;

endpackage

// ===== hdl/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bba_dp.sv =====
module bba_dp (
  input  logic          clk,
  input  logic          rst,
  input  bba_pkg::cmd_t cmd,
  input  bba_pkg::req_t req,
  output bba_pkg::sts_t sts,
  output bba_pkg::rsp_t rsp
);

  logic [1:0] op;
  logic [9:0] off;
  logic too_large;
  logic [bba_pkg::LVL_W-1:0] tl;
  logic [bba_pkg::NODE_W-1:0] n;
  logic [bba_pkg::LVL_W-1:0] level;
  logic [bba_pkg::LEFT_W-1:0] left;
  logic [bba_pkg::NODE_W-1:0] cnt;
  bba_pkg::rsp_t res;

  logic [1:0] rdata;
  logic [bba_pkg::NODE_W-1:0] sib, parent, child_l, child_r, raddr, waddr;
  logic [bba_pkg::LVL_W-1:0] len_sh;
  logic [31:0] units32, half32, goff32;
  logic [10:0] w1, wm1;
  logic [3:0] k;
  logic ld_too_large;

  always_comb begin
    w1 = (req.request_units == 11'd0) ? 11'd1 : req.request_units;
    wm1 = w1 - 11'd1;
    k = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (wm1[i]) begin
        k = 4'(i + 1);
      end
    end
    ld_too_large = 32'(k) > 32'(bba_pkg::TREE_LEVELS);
  end

  assign sib = n[0] ? n + 1'b1 : n - 1'b1;
  assign parent = bba_pkg::NODE_W'(((n + 1'b1) >> 1) - 1'b1);
  assign child_l = bba_pkg::NODE_W'({n, 1'b1});
  assign child_r = bba_pkg::NODE_W'({n, 1'b0} + 2'd2);
  assign len_sh = bba_pkg::LVL_W'(bba_pkg::TREE_LEVELS) - level;
  assign units32 = 32'd1 << len_sh;
  assign half32 = units32 >> 1;
  assign goff32 = (32'(n) + 32'd1 - (32'd1 << level)) << len_sh;

  always_comb begin
    unique case (cmd.rsel)
      bba_pkg::RD_NODE: raddr = n;
      bba_pkg::RD_SIB:  raddr = sib;
      default:          raddr = n;
    endcase
    unique case (cmd.wsel)
      bba_pkg::WS_NODE:    waddr = n;
      bba_pkg::WS_CHILD_L: waddr = child_l;
      bba_pkg::WS_CHILD_R: waddr = child_r;
      bba_pkg::WS_PARENT:  waddr = parent;
      bba_pkg::WS_CLEAR:   waddr = cnt;
      default:             waddr = n;
    endcase
  end

  bba_ram #(.WIDTH(2), .DEPTH(bba_pkg::NODE_COUNT)) u_marks (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (cmd.wmark),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.op = op;
    sts.too_large = too_large;
    sts.off_bad = 32'(off) >= 32'(bba_pkg::POOL_UNITS);
    sts.mark = rdata;
    sts.at_target = level == tl;
    sts.leaf = level == bba_pkg::LVL_W'(bba_pkg::TREE_LEVELS);
    sts.n_root = n == '0;
    sts.n_odd = n[0];
    sts.go_left = 32'(off) < 32'(left) + half32;
    sts.off_eq_left = 32'(off) == 32'(left);
    sts.clr_last = cnt == bba_pkg::NODE_W'(bba_pkg::NODE_COUNT - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req.opcode;
      off <= req.block_offset;
      too_large <= ld_too_large;
      tl <= bba_pkg::LVL_W'(32'(bba_pkg::TREE_LEVELS) - 32'(k));
      n <= '0;
      level <= '0;
      left <= '0;
    end else begin
      unique case (cmd.move)
        bba_pkg::MV_HOLD: ;
        bba_pkg::MV_LEFT: begin
          n <= child_l;
          level <= level + 1'b1;
        end
        bba_pkg::MV_RIGHT: begin
          n <= child_r;
          level <= level + 1'b1;
          left <= bba_pkg::LEFT_W'(32'(left) + half32);
        end
        bba_pkg::MV_NEXT: n <= n + 1'b1;
        bba_pkg::MV_UP: begin
          n <= parent;
          level <= level - 1'b1;
        end
        default: ;
      endcase
    end
    unique case (cmd.res)
      bba_pkg::RS_NONE: ;
      bba_pkg::RS_GRANT: res <= '{bba_pkg::ST_OK, goff32[9:0], units32[10:0]};
      bba_pkg::RS_FOUND: res <= '{bba_pkg::ST_OK, 10'd0, units32[10:0]};
      bba_pkg::RS_FAIL_NS: res <= '{bba_pkg::ST_NOSPACE, 10'd0, 11'd0};
      bba_pkg::RS_FAIL_BAD: res <= '{bba_pkg::ST_BADBLOCK, 10'd0, 11'd0};
      default: ;
    endcase
    if (cmd.publish) begin
      rsp <= res;
    end
  end

endmodule

// ===== hdl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd.rsel = bba_pkg::RD_NODE;
    cmd.wsel = bba_pkg::WS_NODE;
    cmd.move = bba_pkg::MV_HOLD;
    cmd.res = bba_pkg::RS_NONE;
    req_ready = 1'b0;
    state_next = state;
    unique case (state)
      bba_pkg::S_CLR: begin
        cmd.clr = 1'b1;
        cmd.we = 1'b1;
        cmd.wsel = bba_pkg::WS_CLEAR;
        cmd.wmark = bba_pkg::MARK_FREE;
        if (sts.clr_last) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = bba_pkg::S_START;
        end
      end
      bba_pkg::S_START: begin
        if (sts.op == bba_pkg::OP_ALLOC) begin
          if (sts.too_large) begin
            cmd.res = bba_pkg::RS_FAIL_NS;
            state_next = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_A_CHK;
          end
        end else if (sts.op == bba_pkg::OP_FREE || sts.op == bba_pkg::OP_QUERY) begin
          if (sts.off_bad) begin
            cmd.res = bba_pkg::RS_FAIL_BAD;
            state_next = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_Q_CHK;
          end
        end else begin
          cmd.res = bba_pkg::RS_FAIL_NS;
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_A_RD: state_next = bba_pkg::S_A_CHK;
      bba_pkg::S_A_CHK: begin
        if (sts.at_target) begin
          if (sts.mark == bba_pkg::MARK_FREE) begin
            cmd.we = 1'b1;
            cmd.wmark = bba_pkg::MARK_TAKEN;
            cmd.res = bba_pkg::RS_GRANT;
            state_next = bba_pkg::S_F_RD;
          end else begin
            state_next = bba_pkg::S_A_ADV;
          end
        end else if (sts.mark == bba_pkg::MARK_FREE) begin
          cmd.we = 1'b1;
          cmd.wmark = bba_pkg::MARK_SPLIT;
          state_next = bba_pkg::S_A_C1;
        end else if (sts.mark == bba_pkg::MARK_SPLIT) begin
          cmd.move = bba_pkg::MV_LEFT;
          state_next = bba_pkg::S_A_RD;
        end else begin
          state_next = bba_pkg::S_A_ADV;
        end
      end
      bba_pkg::S_A_C1: begin
        cmd.we = 1'b1;
        cmd.wsel = bba_pkg::WS_CHILD_L;
        cmd.wmark = bba_pkg::MARK_FREE;
        state_next = bba_pkg::S_A_C2;
      end
      bba_pkg::S_A_C2: begin
        cmd.we = 1'b1;
        cmd.wsel = bba_pkg::WS_CHILD_R;
        cmd.wmark = bba_pkg::MARK_FREE;
        cmd.move = bba_pkg::MV_LEFT;
        state_next = bba_pkg::S_A_RD;
      end
      bba_pkg::S_A_ADV: begin
        if (sts.n_odd) begin
          cmd.move = bba_pkg::MV_NEXT;
          state_next = bba_pkg::S_A_RD;
        end else if (sts.n_root) begin
          cmd.res = bba_pkg::RS_FAIL_NS;
          state_next = bba_pkg::S_DONE;
        end else begin
          cmd.move = bba_pkg::MV_UP;
        end
      end
      bba_pkg::S_F_RD: begin
        cmd.rsel = bba_pkg::RD_SIB;
        state_next = sts.n_root ? bba_pkg::S_DONE : bba_pkg::S_F_CHK;
      end
      bba_pkg::S_F_CHK: begin
        if (sts.mark == bba_pkg::MARK_TAKEN || sts.mark == bba_pkg::MARK_FULL) begin
          cmd.we = 1'b1;
          cmd.wsel = bba_pkg::WS_PARENT;
          cmd.wmark = bba_pkg::MARK_FULL;
          cmd.move = bba_pkg::MV_UP;
          state_next = bba_pkg::S_F_RD;
        end else begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_Q_RD: state_next = bba_pkg::S_Q_CHK;
      bba_pkg::S_Q_CHK: begin
        if (sts.mark == bba_pkg::MARK_TAKEN) begin
          if (sts.off_eq_left) begin
            cmd.res = bba_pkg::RS_FOUND;
            state_next = (sts.op == bba_pkg::OP_FREE) ? bba_pkg::S_R_RD : bba_pkg::S_DONE;
          end else begin
            cmd.res = bba_pkg::RS_FAIL_BAD;
            state_next = bba_pkg::S_DONE;
          end
        end else if (sts.mark == bba_pkg::MARK_FREE || sts.leaf) begin
          cmd.res = bba_pkg::RS_FAIL_BAD;
          state_next = bba_pkg::S_DONE;
        end else begin
          cmd.move = sts.go_left ? bba_pkg::MV_LEFT : bba_pkg::MV_RIGHT;
          state_next = bba_pkg::S_Q_RD;
        end
      end
      bba_pkg::S_R_RD: begin
        cmd.rsel = bba_pkg::RD_SIB;
        if (sts.n_root) begin
          cmd.we = 1'b1;
          cmd.wmark = bba_pkg::MARK_FREE;
          state_next = bba_pkg::S_DONE;
        end else begin
          state_next = bba_pkg::S_R_CHK;
        end
      end
      bba_pkg::S_R_CHK: begin
        cmd.move = bba_pkg::MV_UP;
        if (sts.mark != bba_pkg::MARK_FREE) begin
          cmd.we = 1'b1;
          cmd.wmark = bba_pkg::MARK_FREE;
          state_next = bba_pkg::S_U_RD;
        end else begin
          state_next = bba_pkg::S_R_RD;
        end
      end
      bba_pkg::S_U_RD: state_next = bba_pkg::S_U_CHK;
      bba_pkg::S_U_CHK: begin
        if (sts.mark == bba_pkg::MARK_FULL) begin
          cmd.we = 1'b1;
          cmd.wmark = bba_pkg::MARK_SPLIT;
          if (sts.n_root) begin
            state_next = bba_pkg::S_DONE;
          end else begin
            cmd.move = bba_pkg::MV_UP;
            state_next = bba_pkg::S_U_RD;
          end
        end else begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/buddy_block_allocator.sv =====
// Channel   Signals                     Moves
// req       req_valid, req_ready, req   opcode, request_units, block_offset
// rsp       rsp_valid, rsp_ready, rsp   status, granted_offset, block_units
//
// After reset a clearing pass writes every node mark, with no request taken.
// One request at a time: accept, start and publish, a read and a check per node visited,
// two child writes per split, and steps up while an allocation backs out of a search.
// Query and free walk down the tree a level at a time; free and a granted allocation
// then climb it, all bounded by the single read and write port of the mark memory.
// A finished result waits in the output register while the next request is taken.
module buddy_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bba_pkg::rsp_t rsp
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .sts (sts),
    .rsp (rsp)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> rsp.status != 2'd3)
    else $error("bad status code");

  a_ok_has_size: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && rsp.status == bba_pkg::ST_OK |-> rsp.block_units != 11'd0)
    else $error("ok result without size");
`endif

endmodule

// ===== tb/bba_checker.sv =====
`timescale 1ns / 1ps

module bba_checker
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  logic [1:0] marks [0:NODE_COUNT-1];
  rsp_t       awaited_rsp [$];

  function automatic int sibling(int n);
    return (n & 1) ? n + 1 : n - 1;
  endfunction

  function automatic int parent(int n);
    return (n + 1) / 2 - 1;
  endfunction

  function automatic void mark_full_upward(int n);
    int s;
    forever begin
      s = sibling(n);
      if (s > 0 && (marks[s] == MARK_TAKEN || marks[s] == MARK_FULL)) begin
        n = parent(n);
        marks[n] = MARK_FULL;
      end else begin
        return;
      end
    end
  endfunction

  function automatic void merge_free(int n);
    int s;
    forever begin
      s = sibling(n);
      if (s < 0 || marks[s] != MARK_FREE) begin
        marks[n] = MARK_FREE;
        n = parent(n);
        while (n >= 0 && marks[n] == MARK_FULL) begin
          marks[n] = MARK_SPLIT;
          n = parent(n);
        end
        return;
      end
      n = parent(n);
    end
  endfunction

  function automatic bit locate_used(int off, output int node, output int units);
    int left;
    int len;
    int n;
    left = 0;
    len = POOL_UNITS;
    n = 0;
    node = 0;
    units = 0;
    if (off >= POOL_UNITS) return 0;
    forever begin
      if (marks[n] == MARK_TAKEN) begin
        if (off != left) return 0;
        node = n;
        units = len;
        return 1;
      end
      if (marks[n] == MARK_FREE || len == 1) return 0;
      len = len >> 1;
      if (off < left + len) begin
        n = 2 * n + 1;
      end else begin
        left = left + len;
        n = 2 * n + 2;
      end
    end
  endfunction

  function automatic bit carve_block(int want, output int offset, output int units);
    int size;
    int len;
    int n;
    int level;
    logic [1:0] m;
    size = 1;
    len = POOL_UNITS;
    n = 0;
    level = 0;
    offset = 0;
    units = 0;
    while (size < want) size = size << 1;
    if (size > POOL_UNITS) return 0;
    forever begin
      if (size == len) begin
        if (marks[n] == MARK_FREE) begin
          marks[n] = MARK_TAKEN;
          mark_full_upward(n);
          offset = ((n + 1) - (1 << level)) << (TREE_LEVELS - level);
          units = size;
          return 1;
        end
      end else begin
        m = marks[n];
        if (m == MARK_FREE) begin
          marks[n] = MARK_SPLIT;
          marks[2 * n + 1] = MARK_FREE;
          marks[2 * n + 2] = MARK_FREE;
          m = MARK_SPLIT;
        end
        if (m == MARK_SPLIT) begin
          n = 2 * n + 1;
          len = len >> 1;
          level++;
          continue;
        end
      end
      if (n & 1) begin
        n++;
        continue;
      end
      forever begin
        level--;
        len = len << 1;
        n = parent(n);
        if (n < 0) return 0;
        if (n & 1) begin
          n++;
          break;
        end
      end
    end
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t res;
    int node;
    int units;
    int offset;
    res = '0;
    res.status = ST_NOSPACE;
    if (r.opcode == OP_ALLOC) begin
      if (carve_block(int'(r.request_units), offset, units)) begin
        res.status = ST_OK;
        res.granted_offset = offset[9:0];
        res.block_units = units[10:0];
      end
    end else if (r.opcode == OP_FREE || r.opcode == OP_QUERY) begin
      if (locate_used(int'(r.block_offset), node, units)) begin
        if (r.opcode == OP_FREE) merge_free(node);
        res.status = ST_OK;
        res.block_units = units[10:0];
      end else begin
        res.status = ST_BADBLOCK;
      end
    end
    return res;
  endfunction

  assign outstanding = awaited_rsp.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      if (mismatches != 0 || awaited_rsp.size() != 0) begin
      end
      for (int i = 0; i < NODE_COUNT; i++) marks[i] = MARK_FREE;
      awaited_rsp.delete();
      mismatches = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected response %h with no request pending", rsp);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status || rsp.granted_offset !== want.granted_offset ||
              rsp.block_units !== want.block_units) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected status %0d offset %0d units %0d, got %0d %0d %0d",
                       want.status, want.granted_offset, want.block_units,
                       rsp.status, rsp.granted_offset, rsp.block_units);
          end
        end
      end
      if (req_valid && req_ready) awaited_rsp = {awaited_rsp, predict_response(req)};
    end
  end

endmodule

// ===== tb/tb_buddy_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   idle_cycles = 0;
  logic [9:0] live_blocks [$];
  logic [1:0] sent_ops [$];

  always #6 clk = ~clk;

  buddy_block_allocator DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  bba_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Track granted blocks so most frees and queries land on real blocks.
  always @(posedge clk) begin
    logic [1:0] op;
    if (!rst) begin
      if (req_valid && req_ready) sent_ops = {sent_ops, req.opcode};
      if (rsp_valid && rsp_ready && sent_ops.size() != 0) begin
        op = sent_ops.pop_front();
        if (op == OP_ALLOC && rsp.status == ST_OK) live_blocks = {live_blocks, rsp.granted_offset};
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input int units, input int offset);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req.opcode <= op;
    req.request_units <= units[10:0];
    req.block_offset <= offset[9:0];
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_random;
    int pick;
    int idx;
    int units;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(19) == 0) units = $urandom_range(2047);
      else if ($urandom_range(9) == 0) units = $urandom_range(1024);
      else units = $urandom_range(40);
      send_request(OP_ALLOC, units, $urandom_range(1023));
    end else if (pick < 80 && live_blocks.size() != 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      send_request(OP_FREE, $urandom_range(2047), live_blocks[idx]);
      live_blocks.delete(idx);
    end else if (pick < 90 && live_blocks.size() != 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      send_request(OP_QUERY, $urandom_range(2047), live_blocks[idx]);
    end else begin
      send_request(logic'($urandom_range(3)) ? 2'($urandom_range(3)) : OP_FREE,
                   $urandom_range(2047), $urandom_range(1023));
    end
  endtask

  task automatic wait_drained;
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    send_request(OP_ALLOC, 1024, 0);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_QUERY, 0, 5);
    send_request(OP_FREE, 0, 1023);
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 0, 0);
    send_request(OP_QUERY, 0, 512);
    send_request(OP_ALLOC, 2047, 0);
    send_request(OP_ALLOC, 1025, 0);
    send_request(2'd3, 2047, 1023);
    send_request(OP_ALLOC, 3, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 512, 0);
    send_request(OP_ALLOC, 512, 0);
    send_request(OP_QUERY, 0, 512);
    send_request(OP_FREE, 0, 1);
    send_request(OP_FREE, 0, 4);
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 0, 512);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_FREE, 0, 0);
    wait_drained();
    live_blocks.delete();
    repeat (40) @(negedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 7 : 0;
      recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 7 : 0;
      for (int i = 0; i < 150; i++) send_random();
      if (ph == 1) wait_drained();
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
